// ===== sv/debug_command_line_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Debug command-line parser assertion macros
// Concurrent checks on the rising clock edge; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DEBUG_COMMAND_LINE_PARSER_ASSERT_SVH
`define DEBUG_COMMAND_LINE_PARSER_ASSERT_SVH

`ifndef SYNTH
// check while out of reset
`define DCLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dclp assertion failed");
// check on every edge, reset included
`define DCLP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dclp assertion failed");
`else
`define DCLP_ASSERT(label, prop)
`define DCLP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== sv/dclp_pkg.sv =====
// ----------------------------------------------------------------------------
// Debug command-line parser package
// Step codes, control word layout, microprogram and character decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dclp_pkg;

  localparam int LINE_DEPTH_DEF = 32;
  localparam int POS_W          = 5;
  localparam int STEP_W         = 4;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_WAIT = 4'd0;
  localparam step_t S_DISP = 4'd1;
  localparam step_t S_RD0  = 4'd2;
  localparam step_t S_RD1  = 4'd3;
  localparam step_t S_CHK  = 4'd4;
  localparam step_t S_ARD  = 4'd5;
  localparam step_t S_ADIG = 4'd6;
  localparam step_t S_VSET = 4'd7;
  localparam step_t S_VRD  = 4'd8;
  localparam step_t S_VDIG = 4'd9;
  localparam step_t S_EMIT = 4'd10;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_BAD      = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_D  = 8'h64;
  localparam logic [7:0] CH_W  = 8'h77;
  localparam logic [7:0] CH_T  = 8'h74;

  localparam pos_t POS_ADDR_FIRST = 5'd3;
  localparam pos_t POS_ADDR_LAST  = 5'd10;
  localparam pos_t POS_ADDR_FULL  = 5'd11;
  localparam pos_t POS_VAL_FIRST  = 5'd12;
  localparam pos_t POS_VAL_LAST   = 5'd19;

  typedef enum logic [1:0] {
    ASEL_NONE = 2'd0,
    ASEL_ZERO = 2'd1,
    ASEL_ONE  = 2'd2,
    ASEL_POS  = 2'd3
  } asel_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_WAIT   = 3'd1,
    ACT_LATCH0 = 3'd2,
    ACT_CHECK  = 3'd3,
    ACT_ADIG   = 3'd4,
    ACT_VSET   = 3'd5,
    ACT_VDIG   = 3'd6,
    ACT_EMIT   = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_STAY     = 3'd1,
    COND_OVF      = 3'd2,
    COND_NOMATCH  = 3'd3,
    COND_ADDR_END = 3'd4,
    COND_READ     = 3'd5,
    COND_VAL_END  = 3'd6,
    COND_OUT_BUSY = 3'd7
  } cond_t;

  typedef struct packed {
    asel_t asel;
    act_t  act;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  typedef struct packed {
    logic stay;
    logic ovf;
    logic nomatch;
    logic addr_end;
    logic is_read;
    logic val_end;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{asel: ASEL_NONE, act: ACT_NONE, cond: COND_NEVER, jmp: S_WAIT, nxt: S_WAIT};
    case (s)
      S_WAIT: w = '{asel: ASEL_NONE, act: ACT_WAIT,   cond: COND_STAY,     jmp: S_WAIT, nxt: S_DISP};
      S_DISP: w = '{asel: ASEL_NONE, act: ACT_NONE,   cond: COND_OVF,      jmp: S_EMIT, nxt: S_RD0};
      S_RD0:  w = '{asel: ASEL_ZERO, act: ACT_NONE,   cond: COND_NEVER,    jmp: S_WAIT, nxt: S_RD1};
      S_RD1:  w = '{asel: ASEL_ONE,  act: ACT_LATCH0, cond: COND_NEVER,    jmp: S_WAIT, nxt: S_CHK};
      S_CHK:  w = '{asel: ASEL_NONE, act: ACT_CHECK,  cond: COND_NOMATCH,  jmp: S_EMIT, nxt: S_ARD};
      S_ARD:  w = '{asel: ASEL_POS,  act: ACT_NONE,   cond: COND_NEVER,    jmp: S_WAIT, nxt: S_ADIG};
      S_ADIG: w = '{asel: ASEL_NONE, act: ACT_ADIG,   cond: COND_ADDR_END, jmp: S_VSET, nxt: S_ARD};
      S_VSET: w = '{asel: ASEL_NONE, act: ACT_VSET,   cond: COND_READ,     jmp: S_EMIT, nxt: S_VRD};
      S_VRD:  w = '{asel: ASEL_POS,  act: ACT_NONE,   cond: COND_NEVER,    jmp: S_WAIT, nxt: S_VDIG};
      S_VDIG: w = '{asel: ASEL_NONE, act: ACT_VDIG,   cond: COND_VAL_END,  jmp: S_EMIT, nxt: S_VRD};
      S_EMIT: w = '{asel: ASEL_NONE, act: ACT_EMIT,   cond: COND_OUT_BUSY, jmp: S_EMIT, nxt: S_WAIT};
      default: w = '{asel: ASEL_NONE, act: ACT_NONE, cond: COND_NEVER, jmp: S_WAIT, nxt: S_WAIT};
    endcase
    return w;
  endfunction

  // bit 4: is a hex digit, bits 3:0: digit value
  function automatic logic [4:0] hex_decode(logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end else if (ch inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== sv/dclp_seq.sv =====
// ----------------------------------------------------------------------------
// Debug command-line parser sequencer
// Step counter over the microprogram table with conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dclp_seq (
  input  logic              clk,
  input  logic              rst,
  input  dclp_pkg::status_t status,
  output dclp_pkg::uword_t  uw,
  output dclp_pkg::step_t   step
);

  logic            taken;
  dclp_pkg::step_t step_next;

  assign uw = dclp_pkg::ucode(step);

  always_comb begin
    case (uw.cond)
      dclp_pkg::COND_NEVER:    taken = 1'b0;
      dclp_pkg::COND_STAY:     taken = status.stay;
      dclp_pkg::COND_OVF:      taken = status.ovf;
      dclp_pkg::COND_NOMATCH:  taken = status.nomatch;
      dclp_pkg::COND_ADDR_END: taken = status.addr_end;
      dclp_pkg::COND_READ:     taken = status.is_read;
      dclp_pkg::COND_VAL_END:  taken = status.val_end;
      dclp_pkg::COND_OUT_BUSY: taken = status.out_busy;
      default:                 taken = 1'b0;
    endcase
    step_next = taken ? uw.jmp : uw.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dclp_pkg::S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== sv/dclp_store.sv =====
// ----------------------------------------------------------------------------
// Debug command-line parser line store
// Byte memory with registered read; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dclp_store #(
  parameter int LINE_DEPTH = dclp_pkg::LINE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [$clog2(LINE_DEPTH)-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic                          re,
  input  logic [$clog2(LINE_DEPTH)-1:0] raddr,
  output logic [7:0]                    rdata
);

  logic [7:0]            mem [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] filled;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (we) begin
      filled[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= filled[raddr] ? mem[raddr] : 8'h00;
    end
  end

endmodule

// ===== sv/debug_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// Debug command-line parser
// An ordinary byte is written to the line store; the next byte is accepted the cycle after.
// A carriage return is parsed by the microprogram, which reads each hex digit
// through the line store read port and then shifts it into the result beat.
// Overflow and bad-command beats skip the digit steps; output stalls hold any beat.
// Synchronous reset empties the line store and clears the write index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "debug_command_line_parser_assert.svh"

module debug_command_line_parser #(
  parameter int LINE_DEPTH = dclp_pkg::LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] target_address,
  output logic [31:0] write_data
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int IW = $clog2(LINE_DEPTH + 1);

  dclp_pkg::uword_t  uw;
  dclp_pkg::step_t   step;
  dclp_pkg::status_t status;

  logic [IW-1:0]   idx;
  dclp_pkg::pos_t  pos;
  logic [31:0]     addr_acc;
  logic [31:0]     val_acc;
  logic [7:0]      ch0;
  logic            wr_cmd;
  logic            ovf;
  dclp_pkg::kind_t kind_q;

  logic          beat;
  logic          idx_full;
  logic          out_busy;
  logic          nomatch;
  logic [4:0]    hx;
  logic          dig_ok;
  logic [3:0]    dig;
  logic          we;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          err_beat;

  dclp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uw     (uw),
    .step   (step)
  );

  dclp_store #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (we),
    .waddr (idx[AW-1:0]),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (step != dclp_pkg::S_WAIT);
  assign beat     = in_valid && !in_stall;
  assign idx_full = (idx >= IW'(LINE_DEPTH));
  assign out_busy = out_valid && out_stall;
  assign hx       = dclp_pkg::hex_decode(rdata);
  assign dig_ok   = hx[4];
  assign dig      = hx[3:0];
  assign nomatch  = !((ch0 == dclp_pkg::CH_R && rdata == dclp_pkg::CH_D) ||
                      (ch0 == dclp_pkg::CH_W && rdata == dclp_pkg::CH_T));
  assign err_beat = out_valid &&
                    (kind == dclp_pkg::KIND_BAD || kind == dclp_pkg::KIND_OVERFLOW);

  always_comb begin
    status.stay     = !beat || (!idx_full && rx_byte != dclp_pkg::CH_CR);
    status.ovf      = ovf;
    status.nomatch  = nomatch;
    status.addr_end = !dig_ok || pos == dclp_pkg::POS_ADDR_LAST;
    status.is_read  = !wr_cmd;
    status.val_end  = !dig_ok || pos == dclp_pkg::POS_VAL_LAST;
    status.out_busy = out_busy;
  end

  always_comb begin
    we    = (uw.act == dclp_pkg::ACT_WAIT && beat && !idx_full) ||
            (uw.act == dclp_pkg::ACT_CHECK && nomatch);
    wdata = (uw.act == dclp_pkg::ACT_WAIT) ? rx_byte : 8'h00;
    re    = (uw.asel != dclp_pkg::ASEL_NONE);
    case (uw.asel)
      dclp_pkg::ASEL_ZERO: raddr = '0;
      dclp_pkg::ASEL_ONE:  raddr = AW'(1);
      dclp_pkg::ASEL_POS:  raddr = AW'(pos);
      default:             raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (uw.act == dclp_pkg::ACT_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (uw.act)
        dclp_pkg::ACT_WAIT: begin
          if (beat && !idx_full && rx_byte != dclp_pkg::CH_CR) begin
            idx <= idx + IW'(1);
          end
        end
        dclp_pkg::ACT_EMIT: begin
          if (!out_busy) begin
            idx <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uw.act)
      dclp_pkg::ACT_WAIT: begin
        if (beat) begin
          ovf      <= idx_full;
          kind_q   <= dclp_pkg::KIND_OVERFLOW;
          addr_acc <= '0;
          val_acc  <= '0;
        end
      end
      dclp_pkg::ACT_LATCH0: begin
        ch0 <= rdata;
      end
      dclp_pkg::ACT_CHECK: begin
        if (nomatch) begin
          kind_q <= dclp_pkg::KIND_BAD;
        end else begin
          wr_cmd <= (ch0 == dclp_pkg::CH_W);
          pos    <= dclp_pkg::POS_ADDR_FIRST;
        end
      end
      dclp_pkg::ACT_ADIG: begin
        if (dig_ok) begin
          addr_acc <= {addr_acc[27:0], dig};
          pos      <= pos + 5'd1;
        end
      end
      dclp_pkg::ACT_VSET: begin
        kind_q <= wr_cmd ? dclp_pkg::KIND_WRITE : dclp_pkg::KIND_READ;
        if (pos == dclp_pkg::POS_ADDR_FULL) begin
          pos <= dclp_pkg::POS_VAL_FIRST;
        end
      end
      dclp_pkg::ACT_VDIG: begin
        if (dig_ok) begin
          val_acc <= {val_acc[27:0], dig};
          pos     <= pos + 5'd1;
        end
      end
      dclp_pkg::ACT_EMIT: begin
        if (!out_busy) begin
          kind           <= kind_q;
          target_address <= addr_acc;
          write_data     <= val_acc;
        end
      end
      default: begin
      end
    endcase
  end

  `DCLP_ASSERT(a_out_from_emit, $rose(out_valid) |-> $past(step) == dclp_pkg::S_EMIT)
  `DCLP_ASSERT(a_err_zero, err_beat |-> target_address == 32'h0 && write_data == 32'h0)
  `DCLP_ASSERT(a_emit_clears, step == dclp_pkg::S_EMIT && !out_busy |=> idx == '0)
  `DCLP_ASSERT(a_idx_range, idx <= IW'(LINE_DEPTH))
  `DCLP_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && idx == '0)

endmodule

// ===== bench/debug_command_line_parser_test.sv =====
// ----------------------------------------------------------------------------
// Debug command-line parser testbench
// Streams console bytes (directed lines, then random read, write, bad,
// overflow and noise lines) through the valid/stall input channel. A
// scoreboard mirrors the line store and write index, predicts each command
// beat, and compares it field by field with what the block returns. Both
// channels idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debug_command_line_parser_test;

  localparam int DEPTH        = dclp_pkg::LINE_DEPTH_DEF;
  localparam int NOT_HEX      = 16;
  localparam int MAX_GAP      = 4;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_BYTES = 1400;
  localparam int MAX_REPORTS  = 10;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  typedef struct packed {
    dclp_pkg::kind_t kind;
    logic [31:0]     addr;
    logic [31:0]     data;
  } cmd_beat_t;

  class line_parser_scoreboard;
    logic [7:0]  line_mem [DEPTH];
    int unsigned wr_idx;
    int unsigned scan_pos;
    cmd_beat_t   expected_q [$];
    int          mismatches;
    int          kind_count [4];

    function new();
      foreach (line_mem[i]) line_mem[i] = 8'h00;
      foreach (kind_count[i]) kind_count[i] = 0;
      wr_idx     = 0;
      scan_pos   = 0;
      mismatches = 0;
    endfunction

    function int digit_of(logic [7:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) return int'(ch - CH_UPPER_A) + 10;
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) return int'(ch - CH_LOWER_A) + 10;
      return NOT_HEX;
    endfunction

    // scan from scan_pos up to last; scan_pos ends on the stopping byte
    function logic [31:0] scan_hex(int unsigned last);
      logic [31:0] acc;
      int          d;
      acc = '0;
      while (scan_pos <= last && scan_pos < DEPTH) begin
        d = digit_of(line_mem[scan_pos]);
        if (d == NOT_HEX) break;
        acc = {acc[27:0], 4'(d)};
        scan_pos++;
      end
      return acc;
    endfunction

    function void note_byte(logic [7:0] b);
      cmd_beat_t r;
      r = '{kind: dclp_pkg::KIND_READ, addr: '0, data: '0};
      if (wr_idx > DEPTH - 1) begin
        wr_idx = 0;
        r.kind = dclp_pkg::KIND_OVERFLOW;
        expected_q.push_back(r);
        return;
      end
      line_mem[wr_idx] = b;
      if (b != dclp_pkg::CH_CR) begin
        wr_idx++;
        return;
      end
      if (!((line_mem[0] == dclp_pkg::CH_R && line_mem[1] == dclp_pkg::CH_D) ||
            (line_mem[0] == dclp_pkg::CH_W && line_mem[1] == dclp_pkg::CH_T))) begin
        line_mem[wr_idx] = 8'h00;
        wr_idx = 0;
        r.kind = dclp_pkg::KIND_BAD;
        expected_q.push_back(r);
        return;
      end
      scan_pos = dclp_pkg::POS_ADDR_FIRST;
      r.addr = scan_hex(dclp_pkg::POS_ADDR_LAST);
      if (line_mem[0] == dclp_pkg::CH_W) begin
        if (scan_pos == dclp_pkg::POS_ADDR_FULL) scan_pos = dclp_pkg::POS_VAL_FIRST;
        r.data = scan_hex(dclp_pkg::POS_VAL_LAST);
        r.kind = dclp_pkg::KIND_WRITE;
      end
      wr_idx = 0;
      expected_q.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(logic [1:0] k, logic [31:0] a, logic [31:0] d);
      cmd_beat_t e;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected beat kind=%0d addr=%h data=%h", k, a, d));
        return;
      end
      e = expected_q.pop_front();
      kind_count[e.kind]++;
      if (e.kind !== k || e.addr !== a || e.data !== d)
        flag($sformatf("kind exp %0d got %0d, addr exp %h got %h, data exp %h got %h",
                       e.kind, k, e.addr, a, e.data, d));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte        = 8'h00;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [1:0]  kind;
  logic [31:0] target_address;
  logic [31:0] write_data;

  line_parser_scoreboard sb;
  logic [7:0] line_q [$];
  int         bytes_sent   = 0;
  int         hold_request = 0;
  bit         in_calm      = 1'b0;
  bit         out_calm     = 1'b0;

  debug_command_line_parser dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .target_address (target_address),
    .write_data     (write_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] rand_non_cr();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == dclp_pkg::CH_CR) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] hex_char(int unsigned v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 10);
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_hex(int n);
    repeat (n) line_q.push_back(hex_char($urandom_range(0, 15)));
  endtask

  task automatic push_sep();
    line_q.push_back($urandom_range(0, 3) == 0 ? rand_non_cr() : CH_SPACE);
  endtask

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic make_random_line();
    int sel;
    int a;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      push_text("rd");
      if ($urandom_range(0, 9) != 0) begin
        push_sep();
        push_hex($urandom_range(1, 8));
        if ($urandom_range(0, 4) == 0) begin
          push_sep();
          push_hex($urandom_range(0, 3));
        end
      end
      line_q.push_back(dclp_pkg::CH_CR);
    end else if (sel < 70) begin
      push_text("wt");
      push_sep();
      a = $urandom_range(0, 1) ? 8 : $urandom_range(0, 8);
      push_hex(a);
      // full address then end of line: value comes from stale bytes
      if (!(a == 8 && $urandom_range(0, 4) == 0)) begin
        push_sep();
        push_hex($urandom_range(0, 8));
        if ($urandom_range(0, 4) == 0) push_hex($urandom_range(1, 4));
      end
      line_q.push_back(dclp_pkg::CH_CR);
    end else if (sel < 82) begin
      case ($urandom_range(0, 4))
        0:       push_text("rt");
        1:       push_text("wd");
        2:       push_text("Rd");
        3:       push_text("wT");
        default: begin
          line_q.push_back(rand_non_cr());
          line_q.push_back(rand_non_cr());
        end
      endcase
      repeat ($urandom_range(0, 6)) line_q.push_back(rand_non_cr());
      line_q.push_back(dclp_pkg::CH_CR);
    end else if (sel < 90) begin
      repeat (DEPTH) line_q.push_back(rand_non_cr());
      line_q.push_back($urandom_range(0, 1) ? dclp_pkg::CH_CR : rand_non_cr());
    end else begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) < 3) line_q.push_back(dclp_pkg::CH_CR);
    end
  endtask

  initial begin : result_sink
    int gap;
    repeat (4) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = out_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      sb.check_result(kind, target_address, write_data);
    end
  end

  initial begin : stimulus
    int lines;
    int base;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // byte extremes, then bad command
    line_q = '{8'h00, 8'hFF, dclp_pkg::CH_CR};
    send_line();
    // full address and value
    push_text("wt 89abCDEF 0123");
    line_q.push_back(dclp_pkg::CH_CR);
    send_line();
    // short address leaves the value at zero
    push_text("wt 5 7");
    line_q.push_back(dclp_pkg::CH_CR);
    send_line();
    // address from stale bytes
    push_text("rd");
    line_q.push_back(dclp_pkg::CH_CR);
    send_line();

    lines = 0;
    base  = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      if (lines % 20 == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      if (lines == 30) hold_request = LONG_HOLD;
      if (lines == 70) begin
        // hold input until every pending beat has drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      make_random_line();
      send_line();
      lines++;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d console bytes in %0d random lines plus directed lines.",
             bytes_sent, lines);
    $display("Beats: %0d read, %0d write, %0d bad command, %0d overflow; %0d mismatches.",
             sb.kind_count[dclp_pkg::KIND_READ], sb.kind_count[dclp_pkg::KIND_WRITE],
             sb.kind_count[dclp_pkg::KIND_BAD], sb.kind_count[dclp_pkg::KIND_OVERFLOW],
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #1_600_000;
    $display("Timeout: block stopped making progress");
    $display("Test completed with failures");
    $finish;
  end

endmodule
